// File: sv/mrs_pkg.sv
// ----------------------------------------------------------------------------
// mrs_pkg
// Shared types and constants for the Modbus RTU slave engine.
// ----------------------------------------------------------------------------
package mrs_pkg;

   // transaction codes on the request channel
   localparam logic [2:0] CMD_RX_BYTE   = 3'd0;
   localparam logic [2:0] CMD_TICK      = 3'd1;
   localparam logic [2:0] CMD_TX_SLOT   = 3'd2;
   localparam logic [2:0] CMD_LOC_WRITE = 3'd3;
   localparam logic [2:0] CMD_LOC_READ  = 3'd4;

   // result kinds
   localparam logic RES_TX_BYTE  = 1'b0;
   localparam logic RES_LOC_READ = 1'b1;

   // CSR indexes
   localparam logic [1:0] CSR_SLAVE_ADDRESS = 2'd0;
   localparam logic [1:0] CSR_PACE_LIMIT    = 2'd1;
   localparam logic [1:0] CSR_GAP_MS        = 2'd2;

   localparam logic [7:0] SLAVE_ADDRESS_RESET = 8'd1;
   localparam logic [7:0] PACE_LIMIT_RESET    = 8'd0;
   localparam logic [6:0] GAP_MS_RESET        = 7'd3;

   // Modbus function codes
   localparam logic [7:0] FN_READ_HOLDING   = 8'd3;
   localparam logic [7:0] FN_READ_INPUT     = 8'd4;
   localparam logic [7:0] FN_WRITE_SINGLE   = 8'd6;
   localparam logic [7:0] FN_WRITE_MULTIPLE = 8'd16;
   localparam logic [7:0] FN_READ_WRITE     = 8'd23;

   localparam logic [15:0] CRC_POLY = 16'hA001;
   localparam logic [15:0] CRC_INIT = 16'hFFFF;

   localparam logic [6:0]  SILENCE_MAX     = 7'd100;
   localparam logic [15:0] MAX_READ_QTY    = 16'd125;
   localparam logic [15:0] MAX_WRITE16_QTY = 16'd123;
   localparam logic [15:0] MAX_WRITE23_QTY = 16'd121;
   localparam int          LEN_EXTRA_WRITE = 9;
   localparam int          LEN_EXTRA_RW    = 13;
   localparam int          WRITE_DATA_POS  = 7;
   localparam int          RW_DATA_POS     = 11;
   localparam int          HDR_BYTES       = 11;

   typedef struct packed {
      logic [2:0]  command;
      logic [7:0]  rx_data;
      logic [15:0] reg_addr;
      logic [15:0] reg_data;
   } req_type;

   typedef struct packed {
      logic        result_kind;
      logic [7:0]  tx_byte;
      logic        tx_last;
      logic [15:0] read_value;
   } rsp_type;

   typedef struct packed {
      logic    valid;
      rsp_type data;
   } res_type;

   typedef struct packed {
      logic [7:0] slave_address;
      logic [7:0] pace_limit;
      logic [6:0] gap_ms;
   } cfg_type;

   typedef struct packed {
      logic        start;
      logic [15:0] seed;
      logic [7:0]  data;
   } crc_req_type;

   typedef struct packed {
      logic        done;
      logic [15:0] value;
   } crc_rsp_type;

   typedef enum logic [4:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RX_FOLD,
      ST_EVAL,
      ST_F6_WRITE,
      ST_WR_HI,
      ST_WR_LO,
      ST_WR_STORE,
      ST_HDR,
      ST_RR_ADDR,
      ST_RR_HI,
      ST_RR_LO,
      ST_RR_NEXT,
      ST_EMIT_WAIT,
      ST_CRC_LO,
      ST_CRC_HI,
      ST_TX_FETCH,
      ST_LOC_FETCH,
      ST_RESULT
   } seq_state_type;

endpackage

// File: sv/mrs_crc_unit.sv
// ----------------------------------------------------------------------------
// mrs_crc_unit
// Bit-serial CRC-16/Modbus: folds one byte into a seed, one bit per cycle.
// ----------------------------------------------------------------------------
module mrs_crc_unit (
   input  logic                 clock,
   input  logic                 reset,
   input  mrs_pkg::crc_req_type crc_req,
   output mrs_pkg::crc_rsp_type crc_rsp
);
   import mrs_pkg::*;

   logic [15:0] crc_ff, crc_in;
   logic [2:0]  bit_ff;
   logic        busy_ff, done_ff;

   always_comb begin
      if (crc_ff[0]) begin
         crc_in = (crc_ff >> 1) ^ CRC_POLY;
      end else begin
         crc_in = crc_ff >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         bit_ff  <= '0;
      end else begin
         done_ff <= busy_ff && (bit_ff == 3'd7);
         if (crc_req.start) begin
            crc_ff  <= crc_req.seed ^ {8'h00, crc_req.data};
            busy_ff <= 1'b1;
            bit_ff  <= '0;
         end else if (busy_ff) begin
            crc_ff <= crc_in;
            bit_ff <= bit_ff + 3'd1;
            if (bit_ff == 3'd7) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   assign crc_rsp.done  = done_ff;
   assign crc_rsp.value = crc_ff;

endmodule

// File: sv/mrs_seq.sv
// ----------------------------------------------------------------------------
// mrs_seq
// Frame sequencer: receive buffer, register stores, frame checks and
// response build, transmit pacing. Drives the shared CRC unit.
// ----------------------------------------------------------------------------
module mrs_seq #(
   parameter int FRAME_BYTES = 256,
   parameter int REG_COUNT   = 256
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_fire,
   input  mrs_pkg::req_type     req,
   output logic                 seq_ready,
   input  mrs_pkg::cfg_type     cfg,
   input  logic                 out_free,
   output mrs_pkg::res_type     res,
   output mrs_pkg::crc_req_type crc_req,
   input  mrs_pkg::crc_rsp_type crc_rsp
);
   import mrs_pkg::*;

   localparam int FW  = $clog2(FRAME_BYTES);
   localparam int CW0 = $clog2(FRAME_BYTES + 1);
   localparam int LW  = (CW0 > 9) ? CW0 : 9;
   localparam int RW  = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
   localparam int RESP_MAX_QTY = (FRAME_BYTES - 5) / 2;
   localparam logic [16:0]   REG_LIMIT   = 17'(REG_COUNT);
   localparam logic [LW-1:0] FRAME_LIMIT = LW'(FRAME_BYTES);

   seq_state_type state_ff, state_in, ret_ff;

   logic [LW-1:0] rx_count_ff, expected_ff, tx_length_ff, tx_index_ff;
   logic [6:0]    silence_ff;
   logic [7:0]    pace_ff;
   logic [15:0]   rx_crc_ff, tx_crc_ff, word_ff;
   logic [7:0]    hdr_ff [HDR_BYTES];
   logic [7:0]    b1_ff, b2_ff, hi_ff;
   logic [RW-1:0] wa_ff, ra_ff, clr_ff;
   logic [6:0]    cnt_ff, wr_qty_ff, rd_qty_ff;
   logic [FW-1:0] rptr_ff, tx_ptr_ff;
   logic [2:0]    hdr_k_ff, hdr_last_ff;
   logic          rep_ff, src_input_ff, loc_ok_ff;
   rsp_type       res_data_ff;

   // memories
   logic [7:0]  rx_mem   [FRAME_BYTES];
   logic [7:0]  tx_mem   [FRAME_BYTES];
   logic [15:0] hold_mem [REG_COUNT];
   logic [15:0] inp_mem  [REG_COUNT];
   logic [7:0]  rx_rd_ff, tx_rd_ff;
   logic [15:0] hold_rd_ff, inp_rd_ff;

   logic          rx_we, tx_we, hold_we, inp_we;
   logic [FW-1:0] rx_wa, tx_wa;
   logic [7:0]    rx_wd, tx_wd;
   logic [RW-1:0] hold_wa, hold_ra, inp_wa;
   logic [15:0]   hold_wd, inp_wd;

   // receive-side decode
   logic          restart, room, rx_take, reg_ok, tx_go;
   logic [LW-1:0] cnt_eff;

   // evaluation
   logic [LW-1:0] n, exp_next;
   logic [7:0]    fn, hdr_byte;
   logic [15:0]   w2, w4, w6, w8, store_rd;
   logic          addr_ok, crc_ok, short_fn, long_fn;
   logic          f6_ok, rd_ok, ok16, ok23, tx_last;

   function automatic logic fits(input logic [15:0] start, input logic [15:0] qty);
      logic [16:0] sum;
      sum = {1'b0, start} + {1'b0, qty};
      return sum <= REG_LIMIT;
   endfunction

   always_comb begin
      restart = silence_ff > cfg.gap_ms;
      cnt_eff = restart ? '0 : rx_count_ff;
      room    = cnt_eff < FRAME_LIMIT;
      rx_take = req_fire && (req.command == CMD_RX_BYTE) && (tx_length_ff == '0) && room;
      reg_ok  = {1'b0, req.reg_addr} < REG_LIMIT;
      tx_go   = (tx_length_ff != '0) && !(pace_ff < cfg.pace_limit) &&
                (tx_index_ff < tx_length_ff);
      tx_last = (tx_index_ff + LW'(1)) == tx_length_ff;

      n   = rx_count_ff;
      fn  = hdr_ff[1];
      w2  = {hdr_ff[2], hdr_ff[3]};
      w4  = {hdr_ff[4], hdr_ff[5]};
      w6  = {hdr_ff[6], hdr_ff[7]};
      w8  = {hdr_ff[8], hdr_ff[9]};
      addr_ok = (n >= LW'(8)) && (hdr_ff[0] == cfg.slave_address);
      if ((n == LW'(8)) && (fn == FN_WRITE_MULTIPLE)) begin
         exp_next = LW'(hdr_ff[6]) + LW'(LEN_EXTRA_WRITE);
      end else if ((n == LW'(11)) && (fn == FN_READ_WRITE)) begin
         exp_next = LW'(hdr_ff[10]) + LW'(LEN_EXTRA_RW);
      end else begin
         exp_next = expected_ff;
      end
      crc_ok   = rx_crc_ff == {b1_ff, b2_ff};
      short_fn = (n == LW'(8)) && ((fn == FN_READ_HOLDING) || (fn == FN_READ_INPUT) ||
                                   (fn == FN_WRITE_SINGLE));
      long_fn  = ((fn == FN_WRITE_MULTIPLE) || (fn == FN_READ_WRITE)) && (n == exp_next);
      f6_ok = {1'b0, w2} < REG_LIMIT;
      rd_ok = (w4 >= 16'd1) && (w4 <= MAX_READ_QTY) && fits(w2, w4) &&
              (w4 <= 16'(RESP_MAX_QTY));
      ok16  = (w4 >= 16'd1) && (w4 <= MAX_WRITE16_QTY) && (hdr_ff[6] == {w4[6:0], 1'b0}) &&
              fits(w2, w4);
      ok23  = rd_ok && (w8 >= 16'd1) && (w8 <= MAX_WRITE23_QTY) &&
              (hdr_ff[10] == {w8[6:0], 1'b0}) && fits(w6, w8);

      store_rd = src_input_ff ? inp_rd_ff : hold_rd_ff;
      if (rep_ff && (hdr_k_ff == 3'd2)) begin
         hdr_byte = {rd_qty_ff, 1'b0};
      end else begin
         hdr_byte = hdr_ff[{1'b0, hdr_k_ff}];
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == RW'(REG_COUNT - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (rx_take) begin
               state_in = (cnt_eff >= LW'(2)) ? ST_RX_FOLD : ST_EVAL;
            end else if (req_fire && (req.command == CMD_TX_SLOT) && tx_go) begin
               state_in = ST_TX_FETCH;
            end else if (req_fire && (req.command == CMD_LOC_READ)) begin
               state_in = ST_LOC_FETCH;
            end
         end
         ST_RX_FOLD: begin
            if (crc_rsp.done) state_in = ST_EVAL;
         end
         ST_EVAL: begin
            state_in = ST_IDLE;
            if (addr_ok && crc_ok) begin
               if (short_fn) begin
                  if (fn == FN_WRITE_SINGLE) begin
                     if (f6_ok) state_in = ST_F6_WRITE;
                  end else if (rd_ok) begin
                     state_in = ST_HDR;
                  end
               end else if (long_fn) begin
                  if ((fn == FN_WRITE_MULTIPLE) ? ok16 : ok23) state_in = ST_WR_HI;
               end
            end
         end
         ST_F6_WRITE:  state_in = ST_HDR;
         ST_WR_HI:     state_in = ST_WR_LO;
         ST_WR_LO:     state_in = ST_WR_STORE;
         ST_WR_STORE:  state_in = (cnt_ff == wr_qty_ff - 7'd1) ? ST_HDR : ST_WR_HI;
         ST_HDR:       state_in = ST_EMIT_WAIT;
         ST_RR_ADDR:   state_in = ST_RR_HI;
         ST_RR_HI:     state_in = ST_EMIT_WAIT;
         ST_RR_LO:     state_in = ST_EMIT_WAIT;
         ST_RR_NEXT:   state_in = (cnt_ff == rd_qty_ff - 7'd1) ? ST_CRC_LO : ST_RR_ADDR;
         ST_EMIT_WAIT: begin
            if (crc_rsp.done) state_in = ret_ff;
         end
         ST_CRC_LO:    state_in = ST_CRC_HI;
         ST_CRC_HI:    state_in = ST_IDLE;
         ST_TX_FETCH:  state_in = ST_RESULT;
         ST_LOC_FETCH: state_in = ST_RESULT;
         ST_RESULT: begin
            if (out_free) state_in = ST_IDLE;
         end
         default:      state_in = ST_IDLE;
      endcase
   end

   // outputs: memory ports, CRC requests, result
   always_comb begin
      hold_we = 1'b0;
      hold_wa = wa_ff;
      hold_wd = {hi_ff, rx_rd_ff};
      hold_ra = ra_ff;
      inp_we  = 1'b0;
      inp_wa  = req.reg_addr[RW-1:0];
      inp_wd  = req.reg_data;
      rx_we   = rx_take;
      rx_wa   = cnt_eff[FW-1:0];
      rx_wd   = req.rx_data;
      tx_we   = 1'b0;
      tx_wa   = tx_ptr_ff;
      tx_wd   = hdr_byte;
      crc_req.start = 1'b0;
      crc_req.seed  = tx_crc_ff;
      crc_req.data  = hdr_byte;
      seq_ready = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            hold_we = 1'b1;
            hold_wa = clr_ff;
            hold_wd = '0;
            inp_we  = 1'b1;
            inp_wa  = clr_ff;
            inp_wd  = '0;
         end
         ST_IDLE: begin
            seq_ready = 1'b1;
            hold_ra   = req.reg_addr[RW-1:0];
            inp_we    = req_fire && (req.command == CMD_LOC_WRITE) && reg_ok;
            if (rx_take && (cnt_eff >= LW'(2))) begin
               crc_req.start = 1'b1;
               crc_req.seed  = rx_crc_ff;
               crc_req.data  = b2_ff;
            end
         end
         ST_F6_WRITE: begin
            hold_we = 1'b1;
            hold_wd = word_ff;
         end
         ST_WR_STORE: hold_we = 1'b1;
         ST_HDR: begin
            tx_we = 1'b1;
            crc_req.start = 1'b1;
         end
         ST_RR_HI: begin
            tx_we = 1'b1;
            tx_wd = store_rd[15:8];
            crc_req.start = 1'b1;
            crc_req.data  = store_rd[15:8];
         end
         ST_RR_LO: begin
            tx_we = 1'b1;
            tx_wd = word_ff[7:0];
            crc_req.start = 1'b1;
            crc_req.data  = word_ff[7:0];
         end
         ST_CRC_LO: begin
            tx_we = 1'b1;
            tx_wd = tx_crc_ff[7:0];
         end
         ST_CRC_HI: begin
            tx_we = 1'b1;
            tx_wd = tx_crc_ff[15:8];
         end
         default: ;
      endcase
      res.valid = state_ff == ST_RESULT;
      res.data  = res_data_ff;
   end

   always_ff @(posedge clock) begin
      if (rx_we) rx_mem[rx_wa] <= rx_wd;
      rx_rd_ff <= rx_mem[rptr_ff];
   end

   always_ff @(posedge clock) begin
      if (tx_we) tx_mem[tx_wa] <= tx_wd;
      tx_rd_ff <= tx_mem[tx_index_ff[FW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (hold_we) hold_mem[hold_wa] <= hold_wd;
      hold_rd_ff <= hold_mem[hold_ra];
   end

   always_ff @(posedge clock) begin
      if (inp_we) inp_mem[inp_wa] <= inp_wd;
      inp_rd_ff <= inp_mem[ra_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rx_count_ff  <= '0;
         expected_ff  <= '0;
         silence_ff   <= '0;
         tx_length_ff <= '0;
         tx_index_ff  <= '0;
         pace_ff      <= '0;
         rx_crc_ff    <= CRC_INIT;
      end else begin
         state_ff <= state_in;
         case (state_ff)
            ST_CLEAR: clr_ff <= clr_ff + RW'(1);
            ST_IDLE: begin
               if (req_fire) begin
                  case (req.command)
                     CMD_RX_BYTE: begin
                        if (tx_length_ff == '0) begin
                           silence_ff <= '0;
                           if (restart) begin
                              expected_ff <= '0;
                              rx_crc_ff   <= CRC_INIT;
                           end
                           rx_count_ff <= room ? cnt_eff + LW'(1) : cnt_eff;
                           if (room) begin
                              b1_ff <= req.rx_data;
                              b2_ff <= b1_ff;
                              if (cnt_eff < LW'(HDR_BYTES)) begin
                                 hdr_ff[cnt_eff[3:0]] <= req.rx_data;
                              end
                           end
                        end
                     end
                     CMD_TICK: begin
                        if (silence_ff < SILENCE_MAX) silence_ff <= silence_ff + 7'd1;
                     end
                     CMD_TX_SLOT: begin
                        if (tx_length_ff != '0) begin
                           if (pace_ff < cfg.pace_limit) begin
                              pace_ff <= pace_ff + 8'd1;
                           end else begin
                              pace_ff <= '0;
                              if (tx_index_ff >= tx_length_ff) begin
                                 tx_length_ff <= '0;
                                 tx_index_ff  <= '0;
                              end
                           end
                        end
                     end
                     CMD_LOC_READ: loc_ok_ff <= reg_ok;
                     default: ;
                  endcase
               end
            end
            ST_RX_FOLD: begin
               if (crc_rsp.done) rx_crc_ff <= crc_rsp.value;
            end
            ST_EVAL: begin
               if (addr_ok) expected_ff <= exp_next;
               tx_ptr_ff <= '0;
               tx_crc_ff <= CRC_INIT;
               hdr_k_ff  <= '0;
               cnt_ff    <= '0;
               if (fn == FN_WRITE_SINGLE) begin
                  wa_ff       <= w2[RW-1:0];
                  word_ff     <= w4;
                  rep_ff      <= 1'b0;
                  hdr_last_ff <= 3'd5;
               end else if (fn == FN_WRITE_MULTIPLE) begin
                  wa_ff       <= w2[RW-1:0];
                  wr_qty_ff   <= w4[6:0];
                  rptr_ff     <= FW'(WRITE_DATA_POS);
                  rep_ff      <= 1'b0;
                  hdr_last_ff <= 3'd5;
               end else if (fn == FN_READ_WRITE) begin
                  wa_ff        <= w6[RW-1:0];
                  wr_qty_ff    <= w8[6:0];
                  rptr_ff      <= FW'(RW_DATA_POS);
                  ra_ff        <= w2[RW-1:0];
                  rd_qty_ff    <= w4[6:0];
                  src_input_ff <= 1'b0;
                  rep_ff       <= 1'b1;
                  hdr_last_ff  <= 3'd2;
               end else begin
                  ra_ff        <= w2[RW-1:0];
                  rd_qty_ff    <= w4[6:0];
                  src_input_ff <= fn == FN_READ_INPUT;
                  rep_ff       <= 1'b1;
                  hdr_last_ff  <= 3'd2;
               end
            end
            ST_WR_HI: rptr_ff <= rptr_ff + FW'(1);
            ST_WR_LO: begin
               hi_ff   <= rx_rd_ff;
               rptr_ff <= rptr_ff + FW'(1);
            end
            ST_WR_STORE: begin
               wa_ff  <= wa_ff + RW'(1);
               cnt_ff <= (cnt_ff == wr_qty_ff - 7'd1) ? 7'd0 : cnt_ff + 7'd1;
            end
            ST_HDR: begin
               tx_ptr_ff <= tx_ptr_ff + FW'(1);
               hdr_k_ff  <= hdr_k_ff + 3'd1;
               if (hdr_k_ff != hdr_last_ff) begin
                  ret_ff <= ST_HDR;
               end else if (rep_ff) begin
                  ret_ff <= ST_RR_ADDR;
               end else begin
                  ret_ff <= ST_CRC_LO;
               end
            end
            ST_RR_HI: begin
               word_ff   <= store_rd;
               tx_ptr_ff <= tx_ptr_ff + FW'(1);
               ret_ff    <= ST_RR_LO;
            end
            ST_RR_LO: begin
               tx_ptr_ff <= tx_ptr_ff + FW'(1);
               ret_ff    <= ST_RR_NEXT;
            end
            ST_RR_NEXT: begin
               ra_ff  <= ra_ff + RW'(1);
               cnt_ff <= cnt_ff + 7'd1;
            end
            ST_EMIT_WAIT: begin
               if (crc_rsp.done) tx_crc_ff <= crc_rsp.value;
            end
            ST_CRC_LO: tx_ptr_ff <= tx_ptr_ff + FW'(1);
            ST_CRC_HI: begin
               tx_length_ff <= LW'(tx_ptr_ff) + LW'(1);
               tx_index_ff  <= '0;
               rx_count_ff  <= '0;
               expected_ff  <= '0;
               rx_crc_ff    <= CRC_INIT;
            end
            ST_TX_FETCH: begin
               res_data_ff.result_kind <= RES_TX_BYTE;
               res_data_ff.tx_byte     <= tx_rd_ff;
               res_data_ff.tx_last     <= tx_last;
               res_data_ff.read_value  <= '0;
               if (tx_last) begin
                  tx_length_ff <= '0;
                  tx_index_ff  <= '0;
               end else begin
                  tx_index_ff <= tx_index_ff + LW'(1);
               end
            end
            ST_LOC_FETCH: begin
               res_data_ff.result_kind <= RES_LOC_READ;
               res_data_ff.tx_byte     <= '0;
               res_data_ff.tx_last     <= 1'b0;
               res_data_ff.read_value  <= loc_ok_ff ? hold_rd_ff : 16'h0000;
            end
            default: ;
         endcase
      end
   end

   a_tx_index_in_frame: assert property (@(posedge clock) disable iff (reset)
      (tx_length_ff != '0) |-> (tx_index_ff < tx_length_ff))
      else $error("tx index ran past the response length");

   a_crc_done_expected: assert property (@(posedge clock) disable iff (reset)
      crc_rsp.done |-> (state_ff == ST_RX_FOLD || state_ff == ST_EMIT_WAIT))
      else $error("CRC result arrived with no one waiting");

   a_rx_count_bound: assert property (@(posedge clock) disable iff (reset)
      rx_count_ff <= FRAME_LIMIT)
      else $error("receive count beyond frame buffer");

endmodule

// File: sv/modbus_rtu_slave_engine_unit.sv
// ----------------------------------------------------------------------------
// modbus_rtu_slave_engine_unit
// Modbus RTU slave: frame collection, CRC check, functions 3/4/6/16/23,
// paced response transmit and local register access.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake            | Payload
//  req_    | in        | req_valid/req_stall  | req_type (command, rx_data, ...)
//  rsp_    | out       | rsp_valid/rsp_stall  | rsp_type (result_kind, tx_byte, ...)
//  csr_    | in        | csr_valid/csr_ready  | csr_index, csr_wdata
//
//  Flow: tick, local write and idle or skipped slot are handled in ST_IDLE;
//  a slot that sends a byte or a local read passes a fetch state and
//  ST_RESULT. Received bytes from the third on are folded by the bit-serial
//  CRC unit. A completed frame stores its written registers, then folds each
//  header and read register byte and appends the CRC bytes.
//  Reset: synchronous; afterwards a clearing pass zeroes both register
//  stores while req_stall stays high. CSR writes are always taken. One
//  result register sits at the output: a transaction may be accepted while
//  a result waits, and a new result waits for rsp_stall low or an empty slot.
// ----------------------------------------------------------------------------
module modbus_rtu_slave_engine_unit #(
   parameter int FRAME_BYTES = 256,
   parameter int REG_COUNT   = 256
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  mrs_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output mrs_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [1:0]       csr_index,
   input  logic [7:0]       csr_wdata
);
   import mrs_pkg::*;

   cfg_type     cfg_ff;
   logic        rsp_valid_ff;
   rsp_type     rsp_data_ff;
   logic        seq_ready, req_fire, out_free;
   res_type     res;
   crc_req_type crc_req;
   crc_rsp_type crc_rsp;

   assign req_stall = !seq_ready;
   assign req_fire  = req_valid && seq_ready;
   // output slot frees when empty or drained this cycle
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.slave_address <= SLAVE_ADDRESS_RESET;
         cfg_ff.pace_limit    <= PACE_LIMIT_RESET;
         cfg_ff.gap_ms        <= GAP_MS_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_SLAVE_ADDRESS: cfg_ff.slave_address <= csr_wdata;
            CSR_PACE_LIMIT:    cfg_ff.pace_limit    <= csr_wdata;
            CSR_GAP_MS:        cfg_ff.gap_ms        <= csr_wdata[6:0];
            default: ;
         endcase
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res.valid && out_free) begin
         rsp_valid_ff <= 1'b1;
         rsp_data_ff  <= res.data;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   mrs_crc_unit u_crc (
      .clock   (clock),
      .reset   (reset),
      .crc_req (crc_req),
      .crc_rsp (crc_rsp)
   );

   mrs_seq #(
      .FRAME_BYTES (FRAME_BYTES),
      .REG_COUNT   (REG_COUNT)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_fire  (req_fire),
      .req       (req_data),
      .seq_ready (seq_ready),
      .cfg       (cfg_ff),
      .out_free  (out_free),
      .res       (res),
      .crc_req   (crc_req),
      .crc_rsp   (crc_rsp)
   );

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the Modbus RTU slave engine: builds request
// frames (good, corrupted, foreign), ticks, paced slots and local accesses,
// predicts every response byte and local read, and compares in order.
// ----------------------------------------------------------------------------
module tb;
   import mrs_pkg::*;

   localparam int FRAME_MAX = 256;
   localparam int REG_MAX   = 256;
   localparam int IDLE_LIMIT = 20000;

   // ------------------------------------------------------------------------
   // Slave behavior model plus in-order result store
   // ------------------------------------------------------------------------
   class slave_scoreboard;
      logic [7:0]  station;
      logic [7:0]  pace;
      logic [6:0]  gap;
      logic [7:0]  rxbuf [FRAME_MAX];
      logic [7:0]  txbuf [FRAME_MAX];
      int          rx_n, want_len, quiet, tx_len, tx_pos, pace_cnt;
      logic [15:0] hold [REG_MAX];
      logic [15:0] inreg [REG_MAX];
      rsp_type     pending [$];
      int          errors, responses, frames_done;

      function new();
         station = SLAVE_ADDRESS_RESET;
         pace = PACE_LIMIT_RESET;
         gap = GAP_MS_RESET;
         rx_n = 0; want_len = 0; quiet = 0; tx_len = 0; tx_pos = 0; pace_cnt = 0;
         errors = 0; responses = 0; frames_done = 0;
         for (int i = 0; i < REG_MAX; i++) begin
            hold[i] = '0;
            inreg[i] = '0;
         end
      endfunction

      function void set_reg(logic [1:0] idx, logic [7:0] v);
         case (idx)
            CSR_SLAVE_ADDRESS: station = v;
            CSR_PACE_LIMIT:    pace = v;
            CSR_GAP_MS:        gap = v[6:0];
            default: ;
         endcase
      endfunction

      function logic [15:0] crc_of(ref logic [7:0] b [FRAME_MAX], input int n);
         logic [15:0] c;
         c = CRC_INIT;
         for (int i = 0; i < n; i++) begin
            c ^= {8'h00, b[i]};
            for (int k = 0; k < 8; k++)
               c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
         end
         return c;
      endfunction

      function bit crc_good(int n);
         logic [15:0] c;
         if (n + 2 > rx_n) return 0;
         c = crc_of(rxbuf, n);
         return rxbuf[n] == c[7:0] && rxbuf[n+1] == c[15:8];
      endfunction

      function int word_at(int p);
         return {rxbuf[p], rxbuf[p+1]};
      endfunction

      function void launch(int len);
         logic [15:0] c;
         c = crc_of(txbuf, len - 2);
         txbuf[len-2] = c[7:0];
         txbuf[len-1] = c[15:8];
         tx_len = len; tx_pos = 0; rx_n = 0; want_len = 0;
         frames_done++;
      endfunction

      function void read_back(int first, int qty, bit from_input);
         logic [15:0] v;
         txbuf[0] = rxbuf[0];
         txbuf[1] = rxbuf[1];
         txbuf[2] = 8'(qty * 2);
         for (int i = 0; i < qty; i++) begin
            v = from_input ? inreg[first+i] : hold[first+i];
            txbuf[3+2*i] = v[15:8];
            txbuf[4+2*i] = v[7:0];
         end
         launch(qty * 2 + 5);
      endfunction

      function void judge_frame();
         int fn, first, qty, rfirst, rqty, wfirst, wqty;
         if (rx_n < 8 || rxbuf[0] != station) return;
         fn = rxbuf[1];
         if (rx_n == 8 && fn == FN_WRITE_MULTIPLE) want_len = rxbuf[6] + LEN_EXTRA_WRITE;
         if (rx_n == 11 && fn == FN_READ_WRITE) want_len = rxbuf[10] + LEN_EXTRA_RW;
         if (rx_n == 8 && (fn == FN_READ_HOLDING || fn == FN_READ_INPUT ||
                           fn == FN_WRITE_SINGLE)) begin
            if (!crc_good(6)) return;
            first = word_at(2);
            if (fn == FN_WRITE_SINGLE) begin
               if (first + 1 > REG_MAX) return;
               hold[first] = 16'(word_at(4));
               for (int i = 0; i < 6; i++) txbuf[i] = rxbuf[i];
               launch(8);
               return;
            end
            qty = word_at(4);
            if (qty < 1 || qty > MAX_READ_QTY || first + qty > REG_MAX ||
                qty * 2 + 5 > FRAME_MAX) return;
            read_back(first, qty, fn == FN_READ_INPUT);
            return;
         end
         if ((fn == FN_WRITE_MULTIPLE || fn == FN_READ_WRITE) && rx_n == want_len) begin
            if (!crc_good(rx_n - 2)) return;
            if (fn == FN_WRITE_MULTIPLE) begin
               first = word_at(2); qty = word_at(4);
               if (qty < 1 || qty > MAX_WRITE16_QTY || rxbuf[6] != qty * 2 ||
                   first + qty > REG_MAX) return;
               for (int i = 0; i < qty; i++)
                  hold[first+i] = 16'(word_at(WRITE_DATA_POS + 2*i));
               for (int i = 0; i < 6; i++) txbuf[i] = rxbuf[i];
               launch(8);
            end else begin
               rfirst = word_at(2); rqty = word_at(4);
               wfirst = word_at(6); wqty = word_at(8);
               if (rqty < 1 || rqty > MAX_READ_QTY || wqty < 1 ||
                   wqty > MAX_WRITE23_QTY || rxbuf[10] != wqty * 2 ||
                   rfirst + rqty > REG_MAX || wfirst + wqty > REG_MAX ||
                   rqty * 2 + 5 > FRAME_MAX) return;
               for (int i = 0; i < wqty; i++)
                  hold[wfirst+i] = 16'(word_at(RW_DATA_POS + 2*i));
               read_back(rfirst, rqty, 0);
            end
         end
      endfunction

      // note one accepted request transaction
      function void note_request(req_type r);
         rsp_type e;
         e = '0;
         case (r.command)
            CMD_RX_BYTE: begin
               if (tx_len == 0) begin
                  if (quiet > gap) begin
                     rx_n = 0; want_len = 0;
                  end
                  quiet = 0;
                  if (rx_n < FRAME_MAX) begin
                     rxbuf[rx_n] = r.rx_data;
                     rx_n++;
                     judge_frame();
                  end
               end
            end
            CMD_TICK: if (quiet < SILENCE_MAX) quiet++;
            CMD_TX_SLOT: begin
               if (tx_len != 0) begin
                  if (pace_cnt < pace) pace_cnt++;
                  else begin
                     pace_cnt = 0;
                     e.result_kind = RES_TX_BYTE;
                     e.tx_byte = txbuf[tx_pos];
                     e.tx_last = (tx_pos + 1 == tx_len);
                     pending.push_back(e);
                     tx_pos++;
                     if (tx_pos == tx_len) begin
                        tx_len = 0; tx_pos = 0;
                     end
                  end
               end
            end
            CMD_LOC_WRITE: if (r.reg_addr < REG_MAX) inreg[r.reg_addr] = r.reg_data;
            CMD_LOC_READ: begin
               e.result_kind = RES_LOC_READ;
               e.read_value = (r.reg_addr < REG_MAX) ? hold[r.reg_addr] : '0;
               pending.push_back(e);
            end
            default: ;
         endcase
      endfunction

      // compare one accepted response transaction with the oldest prediction
      function void check_response(rsp_type got);
         rsp_type e;
         responses++;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected response %h", got);
            return;
         end
         e = pending.pop_front();
         if (got.result_kind !== e.result_kind || got.tx_byte !== e.tx_byte ||
             got.tx_last !== e.tx_last || got.read_value !== e.read_value) begin
            errors++;
            if (errors <= 10)
               $display("response %0d: expected kind %0d byte %h last %0d value %h,",
                        responses, e.result_kind, e.tx_byte, e.tx_last, e.read_value,
                        " got kind %0d byte %h last %0d value %h",
                        got.result_kind, got.tx_byte, got.tx_last, got.read_value);
         end
      endfunction
   endclass

   logic       clock, reset;
   logic       req_valid, req_stall;
   req_type    req_data;
   logic       rsp_valid, rsp_stall;
   rsp_type    rsp_data;
   logic       csr_valid, csr_ready;
   logic [1:0] csr_index;
   logic [7:0] csr_wdata;

   slave_scoreboard sb;
   int  send_idle_pct, stall_pct;
   int  idle_cycles;
   int  sent_items;
   logic [7:0] frame [$];

   modbus_rtu_slave_engine_unit DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // Observe both channels at the rising edge; the watchdog counts cycles in
   // which no transaction moves on either channel.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) sb.note_request(req_data);
         if (rsp_valid && !rsp_stall) sb.check_response(rsp_data);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
         end
      end
   end

   // Receiver side stall, redrawn each falling edge.
   always @(negedge clock)
      rsp_stall <= reset ? 1'b0 : ($urandom_range(99) < stall_pct);

   // Drive one request transaction; random idle before it, held until taken.
   // Valid stays high into the next call so back-to-back items need no gap.
   task automatic send(logic [2:0] cmd, logic [7:0] b = 8'h00,
                       logic [15:0] a = 16'h0000, logic [15:0] d = 16'h0000);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_data <= '{command: cmd, rx_data: b, reg_addr: a, reg_data: d};
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      sent_items++;
   endtask

   task automatic ticks(int n);
      for (int i = 0; i < n; i++) send(CMD_TICK);
   endtask

   // Append the Modbus CRC (low byte first) to the frame under construction.
   task automatic seal_frame();
      logic [15:0] c;
      c = CRC_INIT;
      foreach (frame[i]) begin
         c ^= {8'h00, frame[i]};
         for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      frame.push_back(c[7:0]);
      frame.push_back(c[15:8]);
   endtask

   // Put the frame on the line after a silence, then drain any response.
   task automatic send_frame();
      ticks(sb.gap + 1 > SILENCE_MAX ? SILENCE_MAX : sb.gap + 1);
      foreach (frame[i]) send(CMD_RX_BYTE, frame[i]);
      while (sb.tx_len != 0) send(CMD_TX_SLOT);
   endtask

   task automatic push_word(int w);
      frame.push_back(8'(w >> 8));
      frame.push_back(8'(w));
   endtask

   // Build a request: mostly legal, sometimes out of range, foreign or corrupt.
   task automatic random_frame(bit legal);
      int fn, first, qty, wfirst, wqty;
      frame.delete();
      frame.push_back(($urandom_range(9) == 0) ? 8'($urandom) : sb.station);
      case ($urandom_range(5))
         0: fn = FN_READ_HOLDING;
         1: fn = FN_READ_INPUT;
         2: fn = FN_WRITE_SINGLE;
         3: fn = FN_WRITE_MULTIPLE;
         4: fn = FN_READ_WRITE;
         default: fn = $urandom_range(255);
      endcase
      frame.push_back(8'(fn));
      qty = legal ? $urandom_range(1, 6) : $urandom_range(0, 130);
      first = legal ? $urandom_range(0, REG_MAX - qty) : $urandom_range(0, 65535);
      if ($urandom_range(3) == 0) first = REG_MAX - qty;
      push_word(first);
      if (fn == FN_WRITE_SINGLE) push_word($urandom);
      else push_word(qty);
      if (fn == FN_WRITE_MULTIPLE) begin
         qty = qty > 20 ? 20 : qty;
         frame.push_back(8'(legal ? qty * 2 : $urandom_range(0, 41)));
         for (int i = 0; i < qty; i++) push_word($urandom);
      end else if (fn == FN_READ_WRITE) begin
         wqty = legal ? $urandom_range(1, 6) : $urandom_range(0, 20);
         wfirst = $urandom_range(0, REG_MAX - 1 - (wqty > 0 ? wqty - 1 : 0));
         push_word(wfirst);
         push_word(wqty);
         frame.push_back(8'(legal ? wqty * 2 : $urandom_range(0, 41)));
         for (int i = 0; i < wqty; i++) push_word($urandom);
      end
      seal_frame();
      if (!legal && $urandom_range(2) == 0)
         frame[$urandom_range(frame.size() - 1)] ^= 8'(1 << $urandom_range(7));
      send_frame();
   endtask

   task automatic csr_write(logic [1:0] idx, logic [7:0] v);
      csr_index <= idx;
      csr_wdata <= v;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.set_reg(idx, v);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Let every prediction arrive, then allow the engine to settle.
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (3000) @(negedge clock);
   endtask

   // Random mix of traffic for one phase.
   task automatic random_phase(int n);
      int start;
      start = sent_items;
      while (sent_items - start < n) begin
         case ($urandom_range(9))
            0, 1, 2, 3, 4: random_frame($urandom_range(3) != 0);
            5: send(CMD_LOC_WRITE, 8'($urandom),
                    $urandom_range(3) ? 16'($urandom_range(REG_MAX - 1)) : 16'($urandom),
                    16'($urandom));
            6: send(CMD_LOC_READ, 8'($urandom),
                    $urandom_range(3) ? 16'($urandom_range(REG_MAX - 1)) : 16'($urandom));
            7: send(CMD_RX_BYTE, 8'($urandom));
            8: ticks($urandom_range(1, 5));
            default: send(3'($urandom_range(2, 7)), 8'($urandom), 16'($urandom), 16'($urandom));
         endcase
      end
   endtask

   initial begin
      sb = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_stall = 1'b0;
      csr_valid = 1'b0;
      csr_index = CSR_SLAVE_ADDRESS;
      csr_wdata = '0;
      send_idle_pct = 0;
      stall_pct = 0;
      idle_cycles = 0;
      sent_items = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: reset settings, extreme local accesses, each function
      send(CMD_LOC_WRITE, 8'hFF, 16'd0, 16'hFFFF);
      send(CMD_LOC_WRITE, 8'h00, 16'd255, 16'h8001);
      send(CMD_LOC_WRITE, 8'h00, 16'hFFFF, 16'h1234);     // ignored
      send(CMD_LOC_READ, 8'h00, 16'hFFFF);                 // out of range reads 0
      send(CMD_TX_SLOT);                                   // slot while idle
      frame = '{8'h01, FN_WRITE_SINGLE, 8'h00, 8'hFF, 8'hFF, 8'hFF};
      seal_frame(); send_frame();
      send(CMD_LOC_READ, 8'h00, 16'd255);
      frame = '{8'h01, FN_READ_INPUT, 8'h00, 8'hFE, 8'h00, 8'h02};
      seal_frame(); send_frame();
      frame = '{8'h01, FN_WRITE_MULTIPLE, 8'h00, 8'h10, 8'h00, 8'h02, 8'h04,
                8'hAB, 8'hCD, 8'h00, 8'h01};
      seal_frame(); send_frame();
      frame = '{8'h01, FN_READ_WRITE, 8'h00, 8'h10, 8'h00, 8'h7D, 8'h00, 8'h20,
                8'h00, 8'h01, 8'h02, 8'h55, 8'hAA};
      seal_frame();
      ticks(4);
      foreach (frame[i]) send(CMD_RX_BYTE, frame[i]);
      send(CMD_RX_BYTE, 8'h77);                            // byte while transmitting
      while (sb.tx_len != 0) send(CMD_TX_SLOT);
      frame = '{8'h01, FN_READ_HOLDING, 8'h00, 8'h00, 8'h00, 8'h00}; // zero quantity
      seal_frame(); send_frame();
      drain();

      // config extremes and phases of idling
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin csr_write(CSR_SLAVE_ADDRESS, 8'hFF); csr_write(CSR_PACE_LIMIT, 8'd0);
                     csr_write(CSR_GAP_MS, 7'd0); end
            1: begin csr_write(CSR_SLAVE_ADDRESS, 8'h00); csr_write(CSR_PACE_LIMIT, 8'd3);
                     csr_write(CSR_GAP_MS, 7'd100); end
            2: begin csr_write(CSR_SLAVE_ADDRESS, 8'($urandom));
                     csr_write(CSR_PACE_LIMIT, 8'd5); csr_write(CSR_GAP_MS, 7'd1); end
            default: begin csr_write(CSR_SLAVE_ADDRESS, 8'h5A);
                     csr_write(CSR_PACE_LIMIT, 8'd1); csr_write(CSR_GAP_MS, 7'd127); end
         endcase
         send_idle_pct = (ph == 1) ? 66 : (ph == 3 ? 8 : 0);
         stall_pct     = (ph == 2) ? 66 : (ph == 3 ? 8 : 0);
         random_phase(ph == 2 ? 60 : 80);
         send_idle_pct = 0;
         stall_pct = 0;
         drain();
      end

      $display("Ran %0d request transactions; %0d responses checked, %0d frames answered.",
               sent_items, sb.responses, sb.frames_done);
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("%0d mismatches, %0d responses missing", sb.errors, sb.pending.size());
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
